// File: design/ctd_pkg.sv
// Package for the chunked transfer decoder: widths, types, character codes, helpers.
`timescale 1ns / 1ps
`default_nettype none
package ctd_pkg;

  localparam int SIZE_BITS  = 31;
  localparam int COUNT_BITS = 16;

  localparam logic [SIZE_BITS-1:0]  SIZE_LIMIT  = {SIZE_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = {COUNT_BITS{1'b1}};

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_X_UP  = 8'h58;
  localparam logic [7:0] CHAR_X_LOW = 8'h78;

  localparam logic [4:0] HEX_NONE = 5'd16;

  typedef enum logic [2:0] {
    PH_LINE_START,
    PH_AFTER_SIGN,
    PH_DIGITS,
    PH_SEEK_CRLF,
    PH_DATA,
    PH_TRAILER,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic [7:0]            payload_byte;
    logic                  is_payload;
    logic                  decode_done;
    logic [COUNT_BITS-1:0] decoded_length;
  } result_t;

  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = HEX_NONE;
    if (b inside {[8'h30:8'h39]}) begin
      v = 5'(b - 8'h30);
    end else if (b inside {[8'h61:8'h66]}) begin
      v = 5'(b - 8'h57);
    end else if (b inside {[8'h41:8'h46]}) begin
      v = 5'(b - 8'h37);
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// File: design/chunked_transfer_decoder_unit.sv
// Top level of the HTTP chunked transfer decoder.
//
// Takes one body byte per request and passes on only chunk payload bytes. Size lines are
// parsed as hexadecimal (blanks, sign and 0x prefix accepted, positive overflow saturates),
// the rest of the line is dropped through CR LF, then the chunk data is forwarded and its
// two trailer bytes are skipped. A zero or negative size, or the byte flagged end_of_body,
// ends decoding with a result carrying decode_done and the saturating payload count; after a
// zero size, bytes are dropped up to the flagged byte, then the decoder rearms. For each
// accepted byte, the parse step updates its state registers on the accepting edge and writes
// any result into a two-entry output buffer, so a new request is taken each cycle unless both
// buffer entries hold results not yet taken.
`timescale 1ns / 1ps
`default_nettype none
module chunked_transfer_decoder_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [7:0]                      body_byte_i,
  input  wire logic                            end_of_body_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [7:0]                           payload_byte_o,
  output logic                                 is_payload_o,
  output logic                                 decode_done_o,
  output logic [ctd_pkg::COUNT_BITS-1:0]       decoded_length_o
);

  logic             accept;
  logic             full;
  logic             res_valid;
  ctd_pkg::result_t res;
  ctd_pkg::result_t out_data;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  ctd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .body_byte_i   (body_byte_i),
    .end_of_body_i (end_of_body_i),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  ctd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign payload_byte_o   = out_data.payload_byte;
  assign is_payload_o     = out_data.is_payload;
  assign decode_done_o    = out_data.decode_done;
  assign decoded_length_o = out_data.decoded_length;

  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_payload_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_payload_o |-> decoded_length_o != '0)
    else $error("payload result with zero length");

  a_empty_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_payload_o |-> decode_done_o && payload_byte_o == 8'd0)
    else $error("non-payload result without done");

  a_full_after_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && !out_ready_i |=> !in_ready_o)
    else $error("buffer drained without a pop");

endmodule
`default_nettype wire

// File: design/ctd_core.sv
// Decoder state registers and the per-byte parse step.
`timescale 1ns / 1ps
`default_nettype none
module ctd_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        body_byte_i,
  input  wire logic              end_of_body_i,
  output logic                   res_valid_o,
  output ctd_pkg::result_t       res_o
);

  ctd_pkg::phase_e                  phase_q, phase_d;
  logic [ctd_pkg::SIZE_BITS-1:0]    accum_q, accum_d;
  logic                             neg_q, neg_d;
  logic                             sat_q, sat_d;
  logic                             lz_q, lz_d;
  logic                             cr_q, cr_d;
  logic [ctd_pkg::SIZE_BITS-1:0]    left_q, left_d;
  logic [1:0]                       trail_q, trail_d;
  logic [ctd_pkg::COUNT_BITS-1:0]   count_q, count_d;

  always_comb begin
    logic       run_sign;
    logic       run_digit;
    logic       emit;
    logic       done;
    logic [4:0] d;
    phase_d   = phase_q;
    accum_d   = accum_q;
    neg_d     = neg_q;
    sat_d     = sat_q;
    lz_d      = lz_q;
    cr_d      = cr_q;
    left_d    = left_q;
    trail_d   = trail_q;
    count_d   = count_q;
    run_sign  = 1'b0;
    run_digit = 1'b0;
    emit      = 1'b0;
    done      = 1'b0;
    d         = ctd_pkg::hex_value(body_byte_i);

    case (phase_q)
      ctd_pkg::PH_LINE_START: begin
        accum_d = '0;
        neg_d   = 1'b0;
        sat_d   = 1'b0;
        lz_d    = 1'b0;
        if (body_byte_i == ctd_pkg::CHAR_SPACE || body_byte_i == ctd_pkg::CHAR_TAB ||
            body_byte_i == ctd_pkg::CHAR_LF) begin
          phase_d = ctd_pkg::PH_LINE_START;
        end else if (body_byte_i == ctd_pkg::CHAR_MINUS) begin
          neg_d   = 1'b1;
          phase_d = ctd_pkg::PH_AFTER_SIGN;
        end else if (body_byte_i == ctd_pkg::CHAR_PLUS) begin
          phase_d = ctd_pkg::PH_AFTER_SIGN;
        end else begin
          run_sign = 1'b1;
        end
      end
      ctd_pkg::PH_AFTER_SIGN: run_sign = 1'b1;
      ctd_pkg::PH_DIGITS:     run_digit = 1'b1;
      ctd_pkg::PH_SEEK_CRLF: begin
        if (cr_q && body_byte_i == ctd_pkg::CHAR_LF) begin
          phase_d = ctd_pkg::PH_DATA;
        end else begin
          cr_d = (body_byte_i == ctd_pkg::CHAR_CR);
        end
      end
      ctd_pkg::PH_DATA: begin
        emit = 1'b1;
        if (count_q != ctd_pkg::COUNT_LIMIT) begin
          count_d = count_q + 1'b1;
        end
        if (left_q <= ctd_pkg::SIZE_BITS'(1)) begin
          left_d  = '0;
          trail_d = 2'd2;
          phase_d = ctd_pkg::PH_TRAILER;
        end else begin
          left_d = left_q - 1'b1;
        end
      end
      ctd_pkg::PH_TRAILER: begin
        if (trail_q <= 2'd1) begin
          trail_d = 2'd0;
          phase_d = ctd_pkg::PH_LINE_START;
        end else begin
          trail_d = trail_q - 1'b1;
        end
      end
      default: phase_d = ctd_pkg::PH_DONE;
    endcase

    if (run_sign) begin
      phase_d = ctd_pkg::PH_DIGITS;
      if (body_byte_i == ctd_pkg::CHAR_ZERO) begin
        lz_d = 1'b1;
      end else begin
        run_digit = 1'b1;
      end
    end

    if (run_digit) begin
      if (lz_d && (body_byte_i == ctd_pkg::CHAR_X_LOW || body_byte_i == ctd_pkg::CHAR_X_UP)) begin
        lz_d = 1'b0;
      end else begin
        lz_d = 1'b0;
        if (d == ctd_pkg::HEX_NONE) begin
          if (neg_d || (!sat_d && accum_d == '0)) begin
            phase_d = ctd_pkg::PH_DONE;
            done    = 1'b1;
          end else begin
            left_d  = sat_d ? ctd_pkg::SIZE_LIMIT : accum_d;
            cr_d    = (body_byte_i == ctd_pkg::CHAR_CR);
            phase_d = ctd_pkg::PH_SEEK_CRLF;
          end
        end else if (sat_d || accum_d[ctd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
          sat_d = 1'b1;
        end else begin
          accum_d = {accum_d[ctd_pkg::SIZE_BITS-5:0], d[3:0]};
        end
      end
    end

    if (phase_q == ctd_pkg::PH_DONE) begin
      done = 1'b0;
    end else if (end_of_body_i) begin
      done = 1'b1;
    end

    res_valid_o             = accept_i && (emit || done);
    res_o.payload_byte      = emit ? body_byte_i : 8'd0;
    res_o.is_payload        = emit;
    res_o.decode_done       = done;
    res_o.decoded_length    = count_d;

    if (end_of_body_i) begin
      phase_d = ctd_pkg::PH_LINE_START;
      accum_d = '0;
      neg_d   = 1'b0;
      sat_d   = 1'b0;
      lz_d    = 1'b0;
      cr_d    = 1'b0;
      left_d  = '0;
      trail_d = 2'd0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ctd_pkg::PH_LINE_START;
      accum_q <= '0;
      neg_q   <= 1'b0;
      sat_q   <= 1'b0;
      lz_q    <= 1'b0;
      cr_q    <= 1'b0;
      left_q  <= '0;
      trail_q <= 2'd0;
      count_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      accum_q <= accum_d;
      neg_q   <= neg_d;
      sat_q   <= sat_d;
      lz_q    <= lz_d;
      cr_q    <= cr_d;
      left_q  <= left_d;
      trail_q <= trail_d;
      count_q <= count_d;
    end
  end

endmodule
`default_nettype wire

// File: design/ctd_out_buf.sv
// Two-entry result buffer between the parse step and the output channel.
`timescale 1ns / 1ps
`default_nettype none
module ctd_out_buf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire ctd_pkg::result_t  push_data_i,
  output logic                   full_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ctd_pkg::result_t       out_data_o
);

  ctd_pkg::result_t mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign out_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule
`default_nettype wire
